>>> src/hexf_pkg.sv
// Shared types, constants and helpers of the hex field formatter.
// Used by hexf_front, hexf_desc_fifo, hexf_back and the top level.
package hexf_pkg;

  // Counts of characters fit in 7 bits for any field width up to 64.
  localparam int CNT_W         = 7;
  localparam int VALUE_W       = 64;
  localparam int NIBBLES       = VALUE_W / 4;
  localparam int NIB_IDX_W     = $clog2(NIBBLES);
  localparam int DEF_MAX_WIDTH = 64;

  // ASCII codes used by the formatter.
  localparam logic [6:0] CHAR_NUL   = 7'h00;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_LX    = 7'h78;
  localparam logic [6:0] CHAR_UX    = 7'h58;
  localparam logic [6:0] CHAR_LA    = 7'h61;
  localparam logic [6:0] CHAR_UA    = 7'h41;

  // One classified field: the value plus the end positions of each segment.
  // Segments in order: leading spaces, prefix, zero fill, digits, trailing spaces.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               upper;
    logic               empty;
    logic [CNT_W-1:0]   lead_end;
    logic [CNT_W-1:0]   pfx_end;
    logic [CNT_W-1:0]   fill_end;
    logic [CNT_W-1:0]   dig_end;
    logic [CNT_W-1:0]   total;
  } desc_t;

  // ASCII hex digit for one nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [6:0] base;
    base = upper ? CHAR_UA : CHAR_LA;
    if (nib < 4'd10) begin
      hex_char = CHAR_ZERO + {3'b000, nib};
    end else begin
      hex_char = base + {3'b000, nib - 4'd10};
    end
  endfunction

endpackage

>>> src/hexf_front.sv
// Front part of the hex field formatter: classifies one input beat into a
// segment descriptor. Depends on hexf_pkg.
module hexf_front #(
  parameter int MAX_WIDTH = hexf_pkg::DEF_MAX_WIDTH
) (
  input  logic [hexf_pkg::VALUE_W-1:0] value,
  input  logic                         uppercase,
  input  logic                         alt_form,
  input  logic                         zero_pad,
  input  logic                         left_justify,
  input  logic signed [6:0]            precision,
  input  logic [6:0]                   min_width,
  output hexf_pkg::desc_t              desc
);

  localparam logic [hexf_pkg::CNT_W-1:0] PREC_MAX  = hexf_pkg::CNT_W'(MAX_WIDTH - 2);
  localparam logic [hexf_pkg::CNT_W-1:0] WIDTH_MAX = hexf_pkg::CNT_W'(MAX_WIDTH);

  logic                         prec_given;
  logic [hexf_pkg::CNT_W-1:0]   prec;
  logic [hexf_pkg::CNT_W-1:0]   width;
  logic [hexf_pkg::CNT_W-1:0]   nat_len;
  logic [hexf_pkg::CNT_W-1:0]   digits;
  logic [hexf_pkg::CNT_W-1:0]   add;
  logic [hexf_pkg::CNT_W-1:0]   used;
  logic [hexf_pkg::CNT_W-1:0]   total;
  logic [hexf_pkg::CNT_W-1:0]   pad;
  logic [hexf_pkg::CNT_W-1:0]   lead;
  logic [hexf_pkg::CNT_W-1:0]   fill;
  logic                         value_nz;
  logic                         zero_mode;

  // Natural digit count: one past the highest nonzero nibble, at least one.
  always_comb begin
    nat_len = hexf_pkg::CNT_W'(1);
    for (int i = 0; i < hexf_pkg::NIBBLES; i++) begin
      if (value[4*i +: 4] != 4'h0) begin
        nat_len = hexf_pkg::CNT_W'(i + 1);
      end
    end
  end

  // Clamp precision and width, then size each segment of the field.
  always_comb begin
    value_nz   = (value != '0);
    prec_given = ~precision[6];
    prec       = prec_given ? {1'b0, precision[5:0]} : '0;
    if (prec > PREC_MAX) begin
      prec = PREC_MAX;
    end
    width = (min_width > WIDTH_MAX) ? WIDTH_MAX : min_width;

    digits = nat_len;
    if (prec_given && (prec > digits)) begin
      digits = prec;
    end
    if (!value_nz && prec_given && (prec == '0)) begin
      digits = '0;
    end
    add   = (alt_form && value_nz) ? hexf_pkg::CNT_W'(2) : '0;
    used  = digits + add;
    total = (width > used) ? width : used;
    pad   = total - used;

    zero_mode = zero_pad && !prec_given && !left_justify;
    lead      = (!left_justify && !zero_mode) ? pad : '0;
    fill      = zero_mode ? pad : '0;

    desc.value    = value;
    desc.upper    = uppercase;
    desc.empty    = (total == '0);
    desc.lead_end = lead;
    desc.pfx_end  = lead + add;
    desc.fill_end = lead + add + fill;
    desc.dig_end  = lead + add + fill + digits;
    desc.total    = total;
  end

endmodule

>>> src/hexf_desc_fifo.sv
// Two-entry descriptor queue between the front and back parts.
// Depends on hexf_pkg for the descriptor type.
module hexf_desc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hexf_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output hexf_pkg::desc_t pop_data,
  output logic            empty
);

  hexf_pkg::desc_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  // Storage entries carry payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

>>> src/hexf_back.sv
// Back part of the hex field formatter: walks one descriptor and emits one
// character per unstalled cycle into its output register. Uses hexf_pkg.
module hexf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  hexf_pkg::desc_t desc_in,
  input  logic            desc_empty,
  output logic            desc_pop,
  output logic [6:0]      out_character,
  output logic            out_last,
  output logic            out_empty_res,
  output logic            out_empty,
  input  logic            out_pop
);

  hexf_pkg::desc_t              desc_r;
  logic                         busy_r;
  logic [hexf_pkg::CNT_W-1:0]   pos_r;
  logic                         out_valid_r;
  logic [6:0]                   out_char_r;
  logic                         out_last_r;
  logic                         out_empty_res_r;

  logic                         step;
  logic [6:0]                   char_nxt;
  logic                         last_nxt;
  logic [hexf_pkg::CNT_W-1:0]   dig_idx;
  logic [3:0]                   nib;

  assign out_empty     = !out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_res_r;

  // Take a new descriptor only when the previous field is finished.
  assign desc_pop = !busy_r && !desc_empty;
  assign step     = busy_r && (!out_valid_r || out_pop);

  // Character at the current position, chosen by segment.
  always_comb begin
    dig_idx = desc_r.dig_end - hexf_pkg::CNT_W'(1) - pos_r;
    nib     = 4'h0;
    if (dig_idx < hexf_pkg::CNT_W'(hexf_pkg::NIBBLES)) begin
      nib = 4'(desc_r.value >> {dig_idx[hexf_pkg::NIB_IDX_W-1:0], 2'b00});
    end

    priority if (desc_r.empty) begin
      char_nxt = hexf_pkg::CHAR_NUL;
    end else if (pos_r < desc_r.lead_end) begin
      char_nxt = hexf_pkg::CHAR_SPACE;
    end else if (pos_r < desc_r.pfx_end) begin
      if (pos_r == desc_r.lead_end) begin
        char_nxt = hexf_pkg::CHAR_ZERO;
      end else begin
        char_nxt = desc_r.upper ? hexf_pkg::CHAR_UX : hexf_pkg::CHAR_LX;
      end
    end else if (pos_r < desc_r.fill_end) begin
      char_nxt = hexf_pkg::CHAR_ZERO;
    end else if (pos_r < desc_r.dig_end) begin
      char_nxt = hexf_pkg::hex_char(nib, desc_r.upper);
    end else begin
      char_nxt = hexf_pkg::CHAR_SPACE;
    end

    last_nxt = desc_r.empty || (pos_r == desc_r.total - hexf_pkg::CNT_W'(1));
  end

  // Descriptor hold register.
  always_ff @(posedge clk) begin
    if (desc_pop) begin
      desc_r <= desc_in;
    end
  end

  // Output beat register payload.
  always_ff @(posedge clk) begin
    if (step) begin
      out_char_r      <= char_nxt;
      out_last_r      <= last_nxt;
      out_empty_res_r <= desc_r.empty;
    end
  end

  // Sequencer control and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (desc_pop) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else if (step) begin
        pos_r <= pos_r + hexf_pkg::CNT_W'(1);
        if (last_nxt) begin
          busy_r <= 1'b0;
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> src/printf_hex_field_formatter_top.sv
// Top level of the printf-style hex field formatter.
// Depends on hexf_pkg, hexf_front, hexf_desc_fifo and hexf_back.
//
// Usage:
//   Input side is a queue: drive the value and flags, raise in_push; the
//   beat is taken at a clock edge where in_push is high and in_full is low.
//   Result side is a queue: while out_empty is low, the oldest character
//   beat is on out_character/out_last/out_empty_res and is taken at an edge
//   where out_pop is high. out_last marks the final character of a field; a
//   field with no characters gives one beat with out_empty_res set.
// When the back part is free, the first character of a field passes from the
//   queue entry through the descriptor hold register to the output register.
// Throughput: the back sequencer sets the rate; it loads a field's
//   descriptor, then emits one character per cycle while the receiver
//   takes them, and loads another descriptor only once the field is done.
// The front classifies in the accept cycle and writes a two-entry queue, so
//   up to two further fields are taken while one is being emitted.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// When the receiver stalls, the current beat holds and the back part pauses.
module printf_hex_field_formatter_top #(
  parameter int MAX_WIDTH = hexf_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [hexf_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_uppercase,
  input  logic                         in_alt_form,
  input  logic                         in_zero_pad,
  input  logic                         in_left_justify,
  input  logic signed [6:0]            in_precision,
  input  logic [6:0]                   in_min_width,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [6:0]                   out_character,
  output logic                         out_last,
  output logic                         out_empty_res
);

  hexf_pkg::desc_t front_desc;
  hexf_pkg::desc_t back_desc;
  logic            fifo_empty;
  logic            fifo_pop;

  // Classify the incoming beat.
  hexf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .value        (in_value),
    .uppercase    (in_uppercase),
    .alt_form     (in_alt_form),
    .zero_pad     (in_zero_pad),
    .left_justify (in_left_justify),
    .precision    (in_precision),
    .min_width    (in_min_width),
    .desc         (front_desc)
  );

  // Queue of classified fields.
  hexf_desc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_desc),
    .full      (in_full),
    .pop       (fifo_pop),
    .pop_data  (back_desc),
    .empty     (fifo_empty)
  );

  // Emit characters.
  hexf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .desc_in       (back_desc),
    .desc_empty    (fifo_empty),
    .desc_pop      (fifo_pop),
    .out_character (out_character),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_empty     (out_empty),
    .out_pop       (out_pop)
  );

endmodule

>>> tb/printf_hex_field_formatter_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for printf_hex_field_formatter_top: directed table, then random fields.
// Uses hexf_pkg for widths and ASCII codes, and keeps its own model of the field layout.
module printf_hex_field_formatter_top_tb;

  localparam int MAX_W       = hexf_pkg::DEF_MAX_WIDTH;
  localparam int RAND_FIELDS = 385;
  localparam int CALM_FIRST  = 200;
  localparam int CALM_LAST   = 280;
  localparam int QUIET_LIMIT = 1000;

  // One formatting request as it goes into the block.
  typedef struct packed {
    logic [hexf_pkg::VALUE_W-1:0] value;
    logic                         upper;
    logic                         alt;
    logic                         zpad;
    logic                         left;
    logic signed [6:0]            prec;
    logic [6:0]                   width;
  } hex_req_t;

  // One character beat as it comes out of the block.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       empty;
  } char_beat_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_push = 1'b0;
  logic                         in_full;
  logic [hexf_pkg::VALUE_W-1:0] in_value = '0;
  logic                         in_uppercase = 1'b0;
  logic                         in_alt_form = 1'b0;
  logic                         in_zero_pad = 1'b0;
  logic                         in_left_justify = 1'b0;
  logic signed [6:0]            in_precision = '0;
  logic [6:0]                   in_min_width = '0;
  logic                         out_empty;
  logic                         out_pop = 1'b0;
  logic [6:0]                   out_character;
  logic                         out_last;
  logic                         out_empty_res;

  char_beat_t pending_chars[$];
  logic [6:0] field_text[$];
  hex_req_t   dir_req[$];
  bit         dir_typed[$];
  string      dir_text[$];
  string      lo_digits = "0123456789abcdef";
  string      up_digits = "0123456789ABCDEF";
  bit         calm = 1'b0;
  int         errors = 0;
  int         fields_sent = 0;
  int         beats_seen = 0;
  int         empties_seen = 0;
  int         quiet_cycles = 0;

  printf_hex_field_formatter_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_value        (in_value),
    .in_uppercase    (in_uppercase),
    .in_alt_form     (in_alt_form),
    .in_zero_pad     (in_zero_pad),
    .in_left_justify (in_left_justify),
    .in_precision    (in_precision),
    .in_min_width    (in_min_width),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_character   (out_character),
    .out_last        (out_last),
    .out_empty_res   (out_empty_res)
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hex_req_t req_of(logic [hexf_pkg::VALUE_W-1:0] v, int up, int alt,
                                      int zp, int lj, int p, int w);
    hex_req_t r;
    r = '{value: v, upper: 1'(up), alt: 1'(alt), zpad: 1'(zp), left: 1'(lj),
          prec: 7'(p), width: 7'(w)};
    return r;
  endfunction

  task automatic add_row(input hex_req_t r, input bit typed, input string text);
    dir_req.push_back(r);
    dir_typed.push_back(typed);
    dir_text.push_back(text);
  endtask

  // Turn the collected field text into expected beats; no text means one empty beat.
  task automatic commit_field();
    char_beat_t b;
    if (field_text.size() == 0) begin
      b = '{ch: hexf_pkg::CHAR_NUL, last: 1'b1, empty: 1'b1};
      pending_chars.push_back(b);
    end else begin
      for (int i = 0; i < field_text.size(); i++) begin
        b = '{ch: field_text[i], last: (i == field_text.size() - 1), empty: 1'b0};
        pending_chars.push_back(b);
      end
    end
  endtask

  task automatic load_typed(input string text);
    byte tch;
    field_text.delete();
    for (int i = 0; i < text.len(); i++) begin
      tch = text[i];
      field_text.push_back(tch[6:0]);
    end
    commit_field();
  endtask

  // Lay out one field: padding, prefix, zero fill, digits, in the order the flags select.
  task automatic predict_field(input hex_req_t r);
    int unsigned prec, width, digits, prefix, total, pad, idx;
    bit          given, zero_mode;
    logic [3:0]  nib;
    byte         dch;
    given  = !r.prec[6];
    prec   = given ? int'(r.prec[5:0]) : 0;
    if (prec > MAX_W - 2) prec = MAX_W - 2;
    width  = (r.width > MAX_W) ? MAX_W : r.width;
    digits = 1;
    for (int i = 0; i < hexf_pkg::NIBBLES; i++) begin
      if (r.value[4*i +: 4] != 4'h0) digits = i + 1;
    end
    if (given && prec > digits) digits = prec;
    if (r.value == '0 && given && prec == 0) digits = 0;
    prefix = (r.alt && r.value != '0) ? 2 : 0;
    total  = digits + prefix;
    if (width > total) total = width;
    pad       = total - digits - prefix;
    zero_mode = r.zpad && !given && !r.left;
    field_text.delete();
    if (!r.left && !zero_mode) repeat (pad) field_text.push_back(hexf_pkg::CHAR_SPACE);
    if (prefix != 0) begin
      field_text.push_back(hexf_pkg::CHAR_ZERO);
      field_text.push_back(r.upper ? hexf_pkg::CHAR_UX : hexf_pkg::CHAR_LX);
    end
    if (zero_mode) repeat (pad) field_text.push_back(hexf_pkg::CHAR_ZERO);
    for (int i = 0; i < digits; i++) begin
      idx = digits - 1 - i;
      nib = (idx < hexf_pkg::NIBBLES) ? r.value[4*idx +: 4] : 4'h0;
      dch = r.upper ? up_digits[nib] : lo_digits[nib];
      field_text.push_back(dch[6:0]);
    end
    if (r.left) repeat (pad) field_text.push_back(hexf_pkg::CHAR_SPACE);
    commit_field();
  endtask

  // Random request: mostly short fields, with zeros, full values and wild widths mixed in.
  function automatic hex_req_t random_request();
    hex_req_t                     r;
    int unsigned                  n;
    logic [hexf_pkg::VALUE_W-1:0] mask;
    case ($urandom_range(9))
      0:       r.value = '0;
      1:       r.value = '1;
      2, 3, 4, 5: begin
        n    = $urandom_range(1, hexf_pkg::NIBBLES);
        mask = (n == hexf_pkg::NIBBLES) ? '1 : ((64'h1 << (4 * n)) - 1);
        r.value = {$urandom, $urandom} & mask;
      end
      default: r.value = {$urandom, $urandom};
    endcase
    r.upper = 1'($urandom_range(1));
    r.alt   = 1'($urandom_range(1));
    r.zpad  = 1'($urandom_range(1));
    r.left  = ($urandom_range(3) == 0);
    case ($urandom_range(9))
      0, 1, 2, 3: r.prec = -7'sd1;
      4:          r.prec = '0;
      5, 6, 7:    r.prec = 7'($urandom_range(20));
      8:          r.prec = 7'($urandom_range(21, 63));
      default:    r.prec = 7'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: r.width = 7'($urandom_range(24));
      6, 7:             r.width = 7'($urandom_range(25, MAX_W));
      8:                r.width = 7'($urandom);
      default:          r.width = '0;
    endcase
    return r;
  endfunction

  // Result side: pop at random, except in the calm stretch.
  always @(negedge clk) begin
    out_pop <= calm || ($urandom_range(99) >= 12);
  end

  // Check every accepted character beat against the oldest expectation.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      beats_seen++;
      if (out_empty_res) empties_seen++;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat char=%h last=%b empty_res=%b",
                 $time, out_character, out_last, out_empty_res);
      end else begin
        want = pending_chars.pop_front();
        if ({out_character, out_last, out_empty_res} !== want) begin
          errors++;
          $display("%0t: mismatch char exp=%h got=%h last exp=%b got=%b empty_res exp=%b got=%b",
                   $time, want.ch, out_character, want.last, out_last, want.empty,
                   out_empty_res);
        end
      end
    end
  end

  // Watchdog: too long without any beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, pending_chars.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed table first, then random fields.
  initial begin
    hex_req_t cur;
    int       total_fields;
    add_row(req_of(64'h0, 0, 0, 0, 0, 0, 0), 1, "");
    add_row(req_of(64'h0, 0, 0, 0, 0, -1, 0), 1, "0");
    add_row(req_of('1, 0, 0, 0, 0, -1, 0), 1, "ffffffffffffffff");
    add_row(req_of('1, 1, 0, 0, 0, -1, 0), 1, "FFFFFFFFFFFFFFFF");
    add_row(req_of('1, 1, 1, 0, 0, -1, 0), 1, "0XFFFFFFFFFFFFFFFF");
    add_row(req_of(64'h0, 0, 1, 0, 0, -1, 0), 1, "0");
    add_row(req_of(64'h0, 0, 0, 0, 0, 0, 5), 1, "     ");
    add_row(req_of(64'h0, 0, 1, 0, 0, 0, 0), 1, "");
    add_row(req_of(64'h0, 0, 0, 0, 0, -64, 0), 1, "0");
    add_row(req_of(64'h8000000000000000, 0, 1, 0, 0, -1, 0), 1, "0x8000000000000000");
    add_row(req_of(64'h1, 0, 0, 0, 0, -1, 1), 1, "1");
    add_row(req_of(64'hab, 0, 0, 0, 1, -1, 4), 1, "ab  ");
    add_row(req_of(64'hab, 0, 1, 1, 0, -1, 8), 1, "0x0000ab");
    add_row(req_of(64'h1, 0, 0, 0, 0, 62, 0), 0, "");
    add_row(req_of(64'h1, 0, 0, 0, 0, 63, 0), 0, "");
    add_row(req_of(64'hab, 0, 0, 0, 0, -1, 127), 0, "");
    add_row(req_of(64'h1234, 0, 0, 0, 1, -1, 64), 0, "");
    add_row(req_of(64'hdead, 1, 1, 1, 0, -1, 20), 0, "");
    add_row(req_of(64'hdead, 0, 0, 1, 0, 2, 10), 0, "");
    add_row(req_of(64'hdead, 0, 1, 1, 1, -1, 12), 0, "");
    add_row(req_of('1, 1, 1, 1, 1, 62, 127), 0, "");
    add_row(req_of(64'h123456789abcdef0, 0, 1, 0, 0, 20, 30), 0, "");
    add_row(req_of(64'h0, 0, 0, 1, 0, 0, 64), 0, "");
    add_row(req_of(64'h0, 0, 0, 1, 0, -1, 10), 0, "");
    add_row(req_of(64'hfedcba9876543210, 0, 0, 0, 0, -2, 17), 0, "");
    total_fields = dir_req.size() + RAND_FIELDS;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < total_fields; n++) begin
      cur  = (n < dir_req.size()) ? dir_req[n] : random_request();
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      // Random gaps on the input side, with junk on the data ports.
      while (!calm && $urandom_range(99) < 12) begin
        in_push  <= 1'b0;
        in_value <= {$urandom, $urandom};
        @(negedge clk);
      end
      in_value        <= cur.value;
      in_uppercase    <= cur.upper;
      in_alt_form     <= cur.alt;
      in_zero_pad     <= cur.zpad;
      in_left_justify <= cur.left;
      in_precision    <= cur.prec;
      in_min_width    <= cur.width;
      in_push         <= 1'b1;
      @(posedge clk);
      while (in_full) @(posedge clk);
      fields_sent++;
      if (n < dir_req.size() && dir_typed[n]) load_typed(dir_text[n]);
      else predict_field(cur);
      @(negedge clk);
    end
    in_push <= 1'b0;
    calm    <= 1'b0;

    // Drain, then leave room for any stray beat to show up.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (MAX_W + 8) @(posedge clk);

    $display("Sent %0d fields (%0d from the directed table), checked %0d character beats,",
             fields_sent, dir_req.size(), beats_seen);
    $display("%0d of them empty-field beats; %0d errors.", empties_seen, errors);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
